>>> hdl/ttm_pkg.sv
// Shared types and codes for the task timeout manager.
package ttm_pkg;
    localparam int NumTasksDefault = 16;
    localparam int SlotW = 4;
    localparam int TickW = 32;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_INSERT  = 2'd1;
    localparam logic [1:0] ACT_REMOVE  = 2'd2;
    localparam logic [1:0] ACT_SUSPEND = 2'd3;

    localparam logic [1:0] REP_ACK     = 2'd0;
    localparam logic [1:0] REP_EXPIRED = 2'd1;
    localparam logic [1:0] REP_NONE    = 2'd2;
    localparam logic [1:0] REP_ERROR   = 2'd3;

    localparam logic [1:0] ST_READY     = 2'd0;
    localparam logic [1:0] ST_SUSPENDED = 2'd1;
    localparam logic [1:0] ST_UNCHANGED = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [SlotW-1:0] slot;
        logic [TickW-1:0] delay;
        logic             blocked;
        logic             pending;
        logic             suspended;
        logic             bad_slot;
    } cmd_t;
endpackage

>>> hdl/task_timeout_manager_unit.sv
// Top level of the task timeout manager.
// Requests pass a two-entry queue to the back end. A non-tick request is taken when the
// output register is free and gives one result in the next cycle. A tick first latches
// the set of slots due at the new count, then gives one result per expired task in
// ascending slot order (or a single "none expired" result), each held as long as the
// result register waits on m_tready.
module task_timeout_manager_unit #(
    parameter int NUM_TASKS = ttm_pkg::NumTasksDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0]
    input  logic [1:0]  s_tuser,
    // task_req[3:0], delay[35:4], blocked[36], pending_object[37], suspended[38], zero fill
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // report[1:0]
    output logic [1:0]  m_tuser,
    // task_slot[3:0], new_state[5:4], timed_out[6], detach_pending[7], tick_count[39:8]
    output logic [39:0] m_tdata,
    output logic        m_tlast
);
    logic          q_valid, q_ready;
    ttm_pkg::cmd_t q_cmd;

    ttm_front #(.NUM_TASKS(NUM_TASKS)) u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
        .q_valid, .q_ready, .q_cmd
    );

    ttm_back #(.NUM_TASKS(NUM_TASKS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_tvalid, .m_tready, .m_tuser, .m_tdata, .m_tlast
    );
endmodule

>>> hdl/ttm_front.sv
// Front end: accepts requests, checks the slot range, feeds a two-entry queue.
module ttm_front #(
    parameter int NUM_TASKS = ttm_pkg::NumTasksDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         s_tuser,
    input  logic [39:0]        s_tdata,
    output logic               q_valid,
    input  logic               q_ready,
    output ttm_pkg::cmd_t      q_cmd
);
    ttm_pkg::cmd_t fifo_reg [2];
    logic          wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    ttm_pkg::cmd_t in_cmd;
    logic          push, pop;

    always_comb begin
        in_cmd.action    = s_tuser;
        in_cmd.slot      = s_tdata[3:0];
        in_cmd.delay     = s_tdata[35:4];
        in_cmd.blocked   = s_tdata[36];
        in_cmd.pending   = s_tdata[37];
        in_cmd.suspended = s_tdata[38];
        in_cmd.bad_slot  = ({1'b0, s_tdata[3:0]} >= 5'(NUM_TASKS > 16 ? 16 : NUM_TASKS))
                           && (NUM_TASKS < 16);
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push = s_tvalid && s_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_cmd = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wr_ptr_reg] <= in_cmd;
    end
endmodule

>>> hdl/ttm_back.sv
// Back end: slot state, tick count and the expiry sequencer.
module ttm_back #(
    parameter int NUM_TASKS = ttm_pkg::NumTasksDefault
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  ttm_pkg::cmd_t q_cmd,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [1:0]    m_tuser,
    output logic [39:0]   m_tdata,
    output logic          m_tlast
);
    // only slots 0..15 are reachable through the 4-bit slot field
    localparam int NS = (NUM_TASKS > 16) ? 16 : NUM_TASKS;
    localparam int IW = $clog2(NS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                      state_reg, state_next;
    logic [ttm_pkg::TickW-1:0] tick_reg, tick_next;
    logic [ttm_pkg::TickW-1:0] match_reg [NS];
    logic [NS-1:0] wait_reg, wait_next, blk_reg, blk_next, pend_reg, pend_next;
    logic [NS-1:0] susp_reg, susp_next, due_reg, due_next;

    logic          ovalid_reg, ovalid_next;
    logic [1:0]    ouser_reg, ouser_next;
    logic [39:0]   odata_reg, odata_next;
    logic          olast_reg, olast_next;

    logic                      out_free;
    logic                      mt_we;
    logic [IW-1:0]             req_idx;
    logic [ttm_pkg::TickW-1:0] tick_inc;
    logic [NS-1:0]             due_now, due_rest;
    logic [IW-1:0]             sel;

    assign out_free = !ovalid_reg || m_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tuser  = ouser_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
    assign req_idx  = q_cmd.slot[IW-1:0];
    assign tick_inc = tick_reg + 1'b1;

    function automatic logic [39:0] pack(input logic [3:0] slot, input logic [1:0] st,
                                         input logic tmo, input logic det,
                                         input logic [31:0] tk);
        pack = {tk, det, tmo, st, slot};
    endfunction

    // slots that expire on the incoming tick
    always_comb begin
        for (int i = 0; i < NS; i++)
            due_now[i] = wait_reg[i] && (match_reg[i] == tick_inc);
    end

    // lowest due slot goes out first; last when nothing is left behind it
    always_comb begin
        sel = '0;
        for (int i = NS - 1; i >= 0; i--)
            if (due_reg[i]) sel = IW'(i);
        due_rest = due_reg & ~(NS'(1) << sel);
    end

    always_comb begin
        state_next = state_reg;
        tick_next = tick_reg;
        wait_next = wait_reg;
        blk_next = blk_reg;
        pend_next = pend_reg;
        susp_next = susp_reg;
        due_next = due_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ouser_next = ouser_reg;
        odata_next = odata_reg;
        olast_next = olast_reg;
        q_ready = 1'b0;
        mt_we = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (q_valid && out_free) begin
                    q_ready = 1'b1;
                    if (q_cmd.action == ttm_pkg::ACT_TICK) begin
                        tick_next = tick_inc;
                        due_next = due_now;
                        state_next = S_SCAN;
                    end else begin
                        ovalid_next = 1'b1;
                        olast_next = 1'b1;
                        ouser_next = ttm_pkg::REP_ACK;
                        odata_next = pack(q_cmd.slot, ttm_pkg::ST_UNCHANGED, 1'b0, 1'b0,
                                          tick_reg);
                        if (q_cmd.bad_slot) begin
                            ouser_next = ttm_pkg::REP_ERROR;
                        end else begin
                            case (q_cmd.action)
                                ttm_pkg::ACT_INSERT: begin
                                    if (q_cmd.delay != '0) begin
                                        mt_we = 1'b1;
                                        wait_next[req_idx] = 1'b1;
                                        blk_next[req_idx] = q_cmd.blocked;
                                        pend_next[req_idx] = q_cmd.pending;
                                    end
                                end
                                ttm_pkg::ACT_REMOVE: begin
                                    if (!wait_reg[req_idx]) begin
                                        ouser_next = ttm_pkg::REP_ERROR;
                                    end else begin
                                        wait_next[req_idx] = 1'b0;
                                        blk_next[req_idx] = 1'b0;
                                        pend_next[req_idx] = 1'b0;
                                    end
                                end
                                default: susp_next[req_idx] = q_cmd.suspended;
                            endcase
                        end
                    end
                end
            end
            S_SCAN: begin
                // one result per cycle; stalls while the output register is full and m_tready is low
                if (out_free) begin
                    ovalid_next = 1'b1;
                    if (due_reg == '0) begin
                        ouser_next = ttm_pkg::REP_NONE;
                        odata_next = pack('0, ttm_pkg::ST_UNCHANGED, 1'b0, 1'b0, tick_reg);
                        olast_next = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        ouser_next = ttm_pkg::REP_EXPIRED;
                        odata_next = pack(ttm_pkg::SlotW'(sel),
                                          susp_reg[sel] ? ttm_pkg::ST_SUSPENDED
                                                        : ttm_pkg::ST_READY,
                                          blk_reg[sel], blk_reg[sel] && pend_reg[sel],
                                          tick_reg);
                        olast_next = (due_rest == '0);
                        due_next = due_rest;
                        wait_next[sel] = 1'b0;
                        blk_next[sel] = 1'b0;
                        pend_next[sel] = 1'b0;
                        if (due_rest == '0) state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            tick_reg <= '0;
            wait_reg <= '0;
            blk_reg <= '0;
            pend_reg <= '0;
            susp_reg <= '0;
            due_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            tick_reg <= tick_next;
            wait_reg <= wait_next;
            blk_reg <= blk_next;
            pend_reg <= pend_next;
            susp_reg <= susp_next;
            due_reg <= due_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ouser_reg <= ouser_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
        if (mt_we)
            match_reg[req_idx] <= tick_reg + q_cmd.delay;
    end
endmodule

>>> bench/testbench.sv
// Self-checking bench for the task timeout manager: directed and random requests, predicted results.
module testbench;
    typedef struct packed {
        logic [1:0]  report;
        logic [3:0]  slot;
        logic [1:0]  state;
        logic        tmo;
        logic        det;
        logic [31:0] ticks;
        logic        last;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [1:0]  m_tuser;
    logic [39:0] m_tdata;
    logic        m_tlast;

    task_timeout_manager_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [31:0] now_ticks;
    logic [15:0] armed, blk_mark, pend_mark, susp_mark;
    logic [31:0] due_at [16];

    logic [41:0] request_q [$];
    outcome_t    outcome_q [$];
    int          errors = 0;
    bit          hold_off = 0;

    // tdata fields above the action code in the two low bits
    function automatic logic [41:0] pack_req(logic [1:0] act, logic [3:0] slot,
                                             logic [31:0] dly, logic b, logic p, logic s);
        return {1'b0, s, p, b, dly, slot, act};
    endfunction

    function automatic outcome_t mk(logic [1:0] rep, logic [3:0] slot, logic [1:0] st,
                                    logic tmo, logic det, logic last);
        outcome_t o;
        o.report = rep; o.slot = slot; o.state = st; o.tmo = tmo; o.det = det;
        o.ticks = now_ticks; o.last = last;
        return o;
    endfunction

    task automatic predict_results(logic [1:0] act, logic [39:0] d);
        logic [3:0]  slot;
        logic [31:0] dly;
        int          n;
        outcome_t    o;
        slot = d[3:0]; dly = d[35:4];
        n = 0;
        case (act)
            ttm_pkg::ACT_TICK: begin
                now_ticks = now_ticks + 32'd1;
                for (int i = 0; i < 16; i++) begin
                    if (armed[i] && due_at[i] == now_ticks) begin
                        outcome_q.push_back(mk(ttm_pkg::REP_EXPIRED, 4'(i),
                            susp_mark[i] ? ttm_pkg::ST_SUSPENDED : ttm_pkg::ST_READY,
                            blk_mark[i], blk_mark[i] & pend_mark[i], 1'b0));
                        armed[i] = 1'b0; blk_mark[i] = 1'b0; pend_mark[i] = 1'b0;
                        n++;
                    end
                end
                if (n == 0) begin
                    outcome_q.push_back(mk(ttm_pkg::REP_NONE, 4'd0, ttm_pkg::ST_UNCHANGED,
                                           1'b0, 1'b0, 1'b1));
                end else begin
                    o = outcome_q.pop_back();
                    o.last = 1'b1;
                    outcome_q.push_back(o);
                end
            end
            ttm_pkg::ACT_INSERT: begin
                if (dly != 0) begin
                    due_at[slot] = now_ticks + dly;
                    armed[slot] = 1'b1; blk_mark[slot] = d[36]; pend_mark[slot] = d[37];
                end
                outcome_q.push_back(mk(ttm_pkg::REP_ACK, slot, ttm_pkg::ST_UNCHANGED,
                                       1'b0, 1'b0, 1'b1));
            end
            ttm_pkg::ACT_REMOVE: begin
                if (!armed[slot]) begin
                    outcome_q.push_back(mk(ttm_pkg::REP_ERROR, slot, ttm_pkg::ST_UNCHANGED,
                                           1'b0, 1'b0, 1'b1));
                end else begin
                    armed[slot] = 1'b0; blk_mark[slot] = 1'b0; pend_mark[slot] = 1'b0;
                    outcome_q.push_back(mk(ttm_pkg::REP_ACK, slot, ttm_pkg::ST_UNCHANGED,
                                           1'b0, 1'b0, 1'b1));
                end
            end
            default: begin
                susp_mark[slot] = d[38];
                outcome_q.push_back(mk(ttm_pkg::REP_ACK, slot, ttm_pkg::ST_UNCHANGED,
                                       1'b0, 1'b0, 1'b1));
            end
        endcase
    endtask

    // driver: after each request, wait a drawn number of idle cycles
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_results(s_tuser, s_tdata);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (request_q.size() > 0 && !hold_off) begin
                    {s_tdata, s_tuser} <= request_q.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int rx_gap = 0;
    always @(posedge aclk) begin
        outcome_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = mk(m_tuser, m_tdata[3:0], m_tdata[5:4], m_tdata[6], m_tdata[7],
                         m_tlast);
                got.ticks = m_tdata[39:8];
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result act=%h", $time, got);
                    errors++;
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch exp=%h act=%h", $time, want, got);
                        errors++;
                    end
                end
                rx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
                m_tready <= (rx_gap == 0);
            end else if (rx_gap > 0) begin
                rx_gap = rx_gap - 1;
                m_tready <= (rx_gap == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [41:0] rand_req();
        logic [1:0]  act;
        logic [31:0] dly;
        act = 2'($urandom_range(0, 3));
        if (act == ttm_pkg::ACT_INSERT && $urandom_range(0, 9) != 0) act = ttm_pkg::ACT_TICK;
        case ($urandom_range(0, 9))
            0: dly = 32'd0;
            1: dly = $urandom;
            2: dly = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: dly = $urandom_range(1, 12);
        endcase
        if ($urandom_range(0, 1))
            act = (act == ttm_pkg::ACT_TICK) ? ttm_pkg::ACT_INSERT : act;
        return pack_req(act, 4'($urandom_range(0, 15)), dly, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    initial begin
        now_ticks = 0; armed = 0; blk_mark = 0; pend_mark = 0; susp_mark = 0;
        for (int i = 0; i < 16; i++) due_at[i] = 0;
        // directed: errors, extremes, simultaneous expiry, suspended expiry
        request_q.push_back(pack_req(ttm_pkg::ACT_REMOVE, 4'd15, 32'd0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(pack_req(ttm_pkg::ACT_INSERT, 4'd3, 32'd0, 1'b1, 1'b1, 1'b1));
        request_q.push_back(pack_req(ttm_pkg::ACT_SUSPEND, 4'd15, 32'd0, 1'b0, 1'b0, 1'b1));
        request_q.push_back(pack_req(ttm_pkg::ACT_INSERT, 4'd15, 32'd2, 1'b1, 1'b1, 1'b0));
        request_q.push_back(pack_req(ttm_pkg::ACT_INSERT, 4'd0, 32'd2, 1'b1, 1'b0, 1'b0));
        request_q.push_back(pack_req(ttm_pkg::ACT_INSERT, 4'd7, 32'd2, 1'b0, 1'b1, 1'b0));
        request_q.push_back(pack_req(ttm_pkg::ACT_INSERT, 4'd7, 32'd3, 1'b0, 1'b1, 1'b0));
        request_q.push_back(pack_req(ttm_pkg::ACT_INSERT, 4'd9, 32'd5, 1'b0, 1'b0, 1'b0));
        request_q.push_back(pack_req(ttm_pkg::ACT_REMOVE, 4'd9, 32'd0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(pack_req(ttm_pkg::ACT_INSERT, 4'd1, 32'hFFFF_FFFF,
                                     1'b1, 1'b1, 1'b1));
        request_q.push_back(pack_req(ttm_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(pack_req(ttm_pkg::ACT_TICK, 4'd15, 32'hFFFF_FFFF,
                                     1'b1, 1'b1, 1'b1));
        request_q.push_back(pack_req(ttm_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(pack_req(ttm_pkg::ACT_SUSPEND, 4'd15, 32'd0, 1'b0, 1'b0, 1'b0));
        for (int i = 0; i < 16; i++)
            request_q.push_back(pack_req(ttm_pkg::ACT_INSERT, 4'(i), 32'd1,
                                         1'(i % 2), 1'((i / 2) % 2), 1'b0));
        request_q.push_back(pack_req(ttm_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0, 1'b0, 1'b0));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait (request_q.size() == 0);
        // drain fully once before the random part
        hold_off = 1;
        wait (outcome_q.size() == 0 && !s_tvalid);
        hold_off = 0;
        repeat (340) request_q.push_back(rand_req());
        wait (request_q.size() == 0);
        @(posedge aclk);
        wait (!s_tvalid);
        wait (outcome_q.size() == 0);
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end
endmodule

>>> filelist.f
hdl/ttm_pkg.sv
hdl/ttm_front.sv
hdl/ttm_back.sv
hdl/task_timeout_manager_unit.sv
bench/testbench.sv
